FILE: hdl/pnlt_pkg.sv
// Package for the packed neighbor list table: fixed field widths, beat layouts,
// operation and status codes, and the sequencer state type. No dependencies.
package pnlt_pkg;

   localparam int MODE_W  = 3;
   localparam int PIDX_W  = 10;
   localparam int DIST_W  = 32;
   localparam int SLOT_W  = 5;
   localparam int STAT_W  = 3;
   localparam int LEN_W   = 6;
   localparam int PCNT_W  = 11;

   // request tdata: point_index, distance_bits, slot; padded to whole bytes
   localparam int REQ_PIDX_LO = 0;
   localparam int REQ_DIST_LO = REQ_PIDX_LO + PIDX_W;
   localparam int REQ_SLOT_LO = REQ_DIST_LO + DIST_W;
   localparam int REQ_DATA_W  = 48;

   // response tdata: neighbor_out, distance_out, list_length
   localparam int RSP_NB_LO   = 0;
   localparam int RSP_DIST_LO = RSP_NB_LO + PIDX_W;
   localparam int RSP_LEN_LO  = RSP_DIST_LO + DIST_W;
   localparam int RSP_DATA_W  = 48;

   // one stored entry: neighbor index in the low bits, distance above
   localparam int ENTRY_W = PIDX_W + DIST_W;

   localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PREPARE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ADD     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_COMMIT  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STAT_W-1:0] STAT_LIST_FULL = 3'd1;
   localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 3'd2;
   localparam logic [STAT_W-1:0] STAT_BAD_POINT = 3'd3;
   localparam logic [STAT_W-1:0] STAT_BAD_SLOT  = 3'd4;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_COPY,
      ST_QRY_PT,
      ST_QRY_ST
   } state_type;

endpackage

FILE: hdl/pnlt_ram.sv
// Simple dual-port RAM for the neighbor list table: one write port, one read
// port with registered read data. No package dependencies.
module pnlt_ram #(
   parameter int WIDTH = 42,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/packed_neighbor_list_table_core.sv
// Top level of the packed neighbor list table (compressed sparse row form).
// Uses pnlt_pkg and three pnlt_ram instances (point table, pending list, entry store).
// Prepare, add, mode 5-7, empty or refused commit and bad-point query answer from idle.
// Query: point table read, then shared adder + store read; a slot at or past the count is
// answered after the point table read. Commit: one entry per cycle through the shared
// address adder. Clear: a sweep over every point table entry.
// Throughput: one item at a time; requests are taken in idle with the output free or leaving.
// Reset: synchronous; a clearing pass over all MAX_POINTS entries zeroes the point table first.
module packed_neighbor_list_table_core #(
   parameter int MAX_NEIGHBORS = 32,
   parameter int MAX_POINTS    = 1024,
   parameter int STORE_ENTRIES = 8192
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration: point_count
   input  logic                           csr_wr_en,
   input  logic [pnlt_pkg::PCNT_W-1:0]    csr_wr_data,
   // request stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [9:0] point_index, [41:10] distance_bits, [46:42] slot, [47] zero
   input  logic [pnlt_pkg::REQ_DATA_W-1:0] req_tdata,
   // [2:0] mode
   input  logic [pnlt_pkg::MODE_W-1:0]    req_tuser,
   // response stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [9:0] neighbor_out, [41:10] distance_out, [47:42] list_length
   output logic [pnlt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [2:0] status
   output logic [pnlt_pkg::STAT_W-1:0]    rsp_tuser
);

   localparam int PT_AW   = $clog2(MAX_POINTS);
   localparam int PEND_AW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
   localparam int CNT_W   = $clog2(MAX_NEIGHBORS + 1);
   localparam int OFF_W   = $clog2(STORE_ENTRIES + 1);
   localparam int ST_AW   = $clog2(STORE_ENTRIES);
   localparam int SUM_W   = OFF_W + 1;
   localparam int PT_W    = CNT_W + OFF_W;

   // ---------------------------------------------------------------
   // Request fields
   // ---------------------------------------------------------------
   logic [pnlt_pkg::MODE_W-1:0] req_mode;
   logic [pnlt_pkg::PIDX_W-1:0] req_pidx;
   logic [pnlt_pkg::DIST_W-1:0] req_dist;
   logic [pnlt_pkg::SLOT_W-1:0] req_slot;

   assign req_mode = req_tuser;
   assign req_pidx = req_tdata[pnlt_pkg::REQ_PIDX_LO +: pnlt_pkg::PIDX_W];
   assign req_dist = req_tdata[pnlt_pkg::REQ_DIST_LO +: pnlt_pkg::DIST_W];
   assign req_slot = req_tdata[pnlt_pkg::REQ_SLOT_LO +: pnlt_pkg::SLOT_W];

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   pnlt_pkg::state_type state_ff, state_in;

   logic [pnlt_pkg::PCNT_W-1:0] point_count_ff;
   logic [PT_AW-1:0]            sweep_ff, sweep_in;
   logic                        sweep_rsp_ff, sweep_rsp_in;  // answer when sweep ends
   logic [OFF_W-1:0]            fill_ff, fill_in;
   logic [pnlt_pkg::PIDX_W-1:0] sel_ff, sel_in;
   logic [CNT_W-1:0]            pend_len_ff, pend_len_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;              // pending reads issued
   logic                        wr_vld_ff, wr_vld_in;        // pending read data ready
   logic [OFF_W-1:0]            dst_ff, dst_in;              // next store address
   logic [pnlt_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic                        pos_ok_ff, pos_ok_in;
   logic [CNT_W-1:0]            qlen_ff, qlen_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [pnlt_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [pnlt_pkg::PIDX_W-1:0] rsp_nb_ff, rsp_nb_in;
   logic [pnlt_pkg::DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic [pnlt_pkg::LEN_W-1:0]  rsp_len_ff, rsp_len_in;

   // ---------------------------------------------------------------
   // Memories
   // ---------------------------------------------------------------
   logic                        pt_we, pt_re;
   logic [PT_AW-1:0]            pt_waddr, pt_raddr;
   logic [PT_W-1:0]             pt_wdata, pt_rdata;
   logic [CNT_W-1:0]            pt_cnt;
   logic [OFF_W-1:0]            pt_off;

   logic                        pend_we, pend_re;
   logic [PEND_AW-1:0]          pend_waddr, pend_raddr;
   logic [pnlt_pkg::ENTRY_W-1:0] pend_wdata, pend_rdata;

   logic                        st_we, st_re;
   logic [ST_AW-1:0]            st_waddr, st_raddr;
   logic [pnlt_pkg::ENTRY_W-1:0] st_rdata;

   // point table word: count above offset
   pnlt_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_point_ram (
      .clock   (clock),
      .wr_en   (pt_we),
      .wr_addr (pt_waddr),
      .wr_data (pt_wdata),
      .rd_en   (pt_re),
      .rd_addr (pt_raddr),
      .rd_data (pt_rdata)
   );

   pnlt_ram #(.WIDTH(pnlt_pkg::ENTRY_W), .DEPTH(MAX_NEIGHBORS)) u_pend_ram (
      .clock   (clock),
      .wr_en   (pend_we),
      .wr_addr (pend_waddr),
      .wr_data (pend_wdata),
      .rd_en   (pend_re),
      .rd_addr (pend_raddr),
      .rd_data (pend_rdata)
   );

   // the copy path feeds pending data straight into the store
   pnlt_ram #(.WIDTH(pnlt_pkg::ENTRY_W), .DEPTH(STORE_ENTRIES)) u_store_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (pend_rdata),
      .rd_en   (st_re),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   assign pt_cnt = pt_rdata[OFF_W +: CNT_W];
   assign pt_off = pt_rdata[OFF_W-1:0];

   // ---------------------------------------------------------------
   // Shared address adder: commit bound check in idle, offset + slot for a
   // query, and the store address step during the copy.
   // ---------------------------------------------------------------
   logic [SUM_W-1:0] add_a, add_b, add_sum;

   always_comb begin
      add_a = '0;
      add_b = '0;
      unique case (state_ff)
         pnlt_pkg::ST_IDLE: begin
            add_a = SUM_W'(fill_ff);
            add_b = SUM_W'(pend_len_ff);
         end
         pnlt_pkg::ST_QRY_PT: begin
            add_a = SUM_W'(pt_off);
            add_b = SUM_W'(slot_ff);
         end
         pnlt_pkg::ST_COPY: begin
            add_a = SUM_W'(dst_ff);
            add_b = SUM_W'(1);
         end
         default: begin
         end
      endcase
   end

   assign add_sum = add_a + add_b;

   // ---------------------------------------------------------------
   // Decisions shared by the next-state and datapath blocks
   // ---------------------------------------------------------------
   logic accept;
   logic pidx_ok, sel_ok, pend_empty, pend_full, store_over;
   logic slot_over, copy_done, sweep_last, start_copy;

   assign accept     = req_tvalid && req_tready;
   assign pidx_ok    = (pnlt_pkg::PCNT_W'(req_pidx) < point_count_ff)
                       && (32'(req_pidx) < 32'(MAX_POINTS));
   assign sel_ok     = (pnlt_pkg::PCNT_W'(sel_ff) < point_count_ff)
                       && (32'(sel_ff) < 32'(MAX_POINTS));
   assign pend_empty = (pend_len_ff == '0);
   assign pend_full  = (pend_len_ff == CNT_W'(MAX_NEIGHBORS));
   assign store_over = (add_sum > SUM_W'(STORE_ENTRIES));
   assign start_copy = !pend_empty && sel_ok && !store_over;
   assign slot_over  = (8'(slot_ff) >= 8'(pt_cnt));
   assign copy_done  = (cnt_ff == pend_len_ff) && !wr_vld_ff;
   assign sweep_last = (sweep_ff == PT_AW'(MAX_POINTS - 1));

   // hold off requests while busy or while a result cannot leave this cycle
   assign req_tready = (state_ff == pnlt_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);

   // ---------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pnlt_pkg::ST_SWEEP: begin
            if (sweep_last) begin
               state_in = pnlt_pkg::ST_IDLE;
            end
         end
         pnlt_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  pnlt_pkg::MODE_CLEAR:  state_in = pnlt_pkg::ST_SWEEP;
                  pnlt_pkg::MODE_COMMIT: begin
                     if (start_copy) begin
                        state_in = pnlt_pkg::ST_COPY;
                     end
                  end
                  pnlt_pkg::MODE_QUERY: begin
                     if (pidx_ok) begin
                        state_in = pnlt_pkg::ST_QRY_PT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         pnlt_pkg::ST_COPY: begin
            if (copy_done) begin
               state_in = pnlt_pkg::ST_IDLE;
            end
         end
         pnlt_pkg::ST_QRY_PT: begin
            state_in = slot_over ? pnlt_pkg::ST_IDLE : pnlt_pkg::ST_QRY_ST;
         end
         pnlt_pkg::ST_QRY_ST: state_in = pnlt_pkg::ST_IDLE;
         default: state_in = pnlt_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // Datapath and memory control
   // ---------------------------------------------------------------
   logic                        load;
   logic [pnlt_pkg::STAT_W-1:0] res_status;
   logic [pnlt_pkg::PIDX_W-1:0] res_nb;
   logic [pnlt_pkg::DIST_W-1:0] res_dist;
   logic [pnlt_pkg::LEN_W-1:0]  res_len;

   always_comb begin
      sweep_in     = sweep_ff;
      sweep_rsp_in = sweep_rsp_ff;
      fill_in      = fill_ff;
      sel_in       = sel_ff;
      pend_len_in  = pend_len_ff;
      cnt_in       = cnt_ff;
      wr_vld_in    = wr_vld_ff;
      dst_in       = dst_ff;
      slot_in      = slot_ff;
      pos_ok_in    = pos_ok_ff;
      qlen_in      = qlen_ff;

      pt_we      = 1'b0;
      pt_waddr   = sweep_ff;
      pt_wdata   = '0;
      pt_re      = 1'b0;
      pt_raddr   = PT_AW'(req_pidx);
      pend_we    = 1'b0;
      pend_waddr = PEND_AW'(pend_len_ff);
      pend_wdata = {req_dist, req_pidx};
      pend_re    = 1'b0;
      pend_raddr = PEND_AW'(cnt_ff);
      st_we      = 1'b0;
      st_waddr   = ST_AW'(dst_ff);
      st_re      = 1'b0;
      st_raddr   = ST_AW'(add_sum);

      load       = 1'b0;
      res_status = pnlt_pkg::STAT_OK;
      res_nb     = '0;
      res_dist   = '0;
      res_len    = '0;

      unique case (state_ff)
         pnlt_pkg::ST_SWEEP: begin
            // zero one point entry a cycle
            pt_we    = 1'b1;
            sweep_in = sweep_ff + PT_AW'(1);
            if (sweep_last) begin
               load = sweep_rsp_ff;
            end
         end
         pnlt_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  pnlt_pkg::MODE_CLEAR: begin
                     fill_in      = '0;
                     sweep_in     = '0;
                     sweep_rsp_in = 1'b1;
                  end
                  pnlt_pkg::MODE_PREPARE: begin
                     load = 1'b1;
                     if (pidx_ok) begin
                        sel_in      = req_pidx;
                        pend_len_in = '0;
                     end else begin
                        res_status = pnlt_pkg::STAT_BAD_POINT;
                     end
                  end
                  pnlt_pkg::MODE_ADD: begin
                     load = 1'b1;
                     if (pend_full) begin
                        res_status = pnlt_pkg::STAT_LIST_FULL;
                        res_len    = pnlt_pkg::LEN_W'(pend_len_ff);
                     end else begin
                        pend_we     = 1'b1;
                        pend_len_in = pend_len_ff + CNT_W'(1);
                        res_len     = pnlt_pkg::LEN_W'(pend_len_ff + CNT_W'(1));
                     end
                  end
                  pnlt_pkg::MODE_COMMIT: begin
                     if (pend_empty) begin
                        load = 1'b1;
                     end else if (!sel_ok) begin
                        load       = 1'b1;
                        res_status = pnlt_pkg::STAT_BAD_POINT;
                     end else if (store_over) begin
                        load       = 1'b1;
                        res_status = pnlt_pkg::STAT_OVERFLOW;
                     end else begin
                        // record count and offset now, then copy entries
                        pt_we     = 1'b1;
                        pt_waddr  = PT_AW'(sel_ff);
                        pt_wdata  = {pend_len_ff, fill_ff};
                        cnt_in    = '0;
                        wr_vld_in = 1'b0;
                        dst_in    = fill_ff;
                     end
                  end
                  pnlt_pkg::MODE_QUERY: begin
                     if (pidx_ok) begin
                        pt_re   = 1'b1;
                        slot_in = req_slot;
                     end else begin
                        load       = 1'b1;
                        res_status = pnlt_pkg::STAT_BAD_POINT;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         pnlt_pkg::ST_COPY: begin
            // read one pending entry, write the one whose read data is registered
            if (cnt_ff != pend_len_ff) begin
               pend_re   = 1'b1;
               cnt_in    = cnt_ff + CNT_W'(1);
               wr_vld_in = 1'b1;
            end else begin
               wr_vld_in = 1'b0;
            end
            if (wr_vld_ff) begin
               st_we  = 1'b1;
               dst_in = OFF_W'(add_sum);
            end
            if (copy_done) begin
               fill_in = dst_ff;
               load    = 1'b1;
            end
         end
         pnlt_pkg::ST_QRY_PT: begin
            if (slot_over) begin
               load       = 1'b1;
               res_status = pnlt_pkg::STAT_BAD_SLOT;
               res_len    = pnlt_pkg::LEN_W'(pt_cnt);
            end else begin
               st_re     = 1'b1;
               pos_ok_in = (add_sum < SUM_W'(STORE_ENTRIES));
               qlen_in   = pt_cnt;
            end
         end
         pnlt_pkg::ST_QRY_ST: begin
            load    = 1'b1;
            res_len = pnlt_pkg::LEN_W'(qlen_ff);
            if (pos_ok_ff) begin
               res_nb   = st_rdata[pnlt_pkg::PIDX_W-1:0];
               res_dist = st_rdata[pnlt_pkg::PIDX_W +: pnlt_pkg::DIST_W];
            end
         end
         default: begin
         end
      endcase
   end

   // output register: a new result only loads when the slot is free or leaving
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_nb_in     = rsp_nb_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_len_in    = rsp_len_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status;
         rsp_nb_in     = res_nb;
         rsp_dist_in   = res_dist;
         rsp_len_in    = res_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pnlt_pkg::ST_SWEEP;
         point_count_ff <= '0;
         sweep_ff       <= '0;
         sweep_rsp_ff   <= 1'b0;
         fill_ff        <= '0;
         sel_ff         <= '0;
         pend_len_ff    <= '0;
         cnt_ff         <= '0;
         wr_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            point_count_ff <= csr_wr_data;
         end
         sweep_ff     <= sweep_in;
         sweep_rsp_ff <= sweep_rsp_in;
         fill_ff      <= fill_in;
         sel_ff       <= sel_in;
         pend_len_ff  <= pend_len_in;
         cnt_ff       <= cnt_in;
         wr_vld_ff    <= wr_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dst_ff        <= dst_in;
      slot_ff       <= slot_in;
      pos_ok_ff     <= pos_ok_in;
      qlen_ff       <= qlen_in;
      rsp_status_ff <= rsp_status_in;
      rsp_nb_ff     <= rsp_nb_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_len_ff, rsp_dist_ff, rsp_nb_ff};

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // the entry store is only written by the commit copy
   a_store_write_in_copy: assert property (@(posedge clock) disable iff (reset)
      st_we |-> (state_ff == pnlt_pkg::ST_COPY))
      else $error("store written outside commit copy");

   // the fill pointer never runs past the end of the store
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= 32'(STORE_ENTRIES))
      else $error("fill pointer beyond store");

   // the pending count never passes the list capacity
   a_pend_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(pend_len_ff) <= 32'(MAX_NEIGHBORS))
      else $error("pending count beyond capacity");

   // a finished copy has advanced the store address by the pending count
   a_copy_span: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == pnlt_pkg::ST_COPY) && copy_done)
      |-> (32'(dst_ff) == 32'(fill_ff) + 32'(pend_len_ff)))
      else $error("commit copy wrote a wrong number of entries");

endmodule

FILE: dv/pnlt_checker.sv
// Response checker for packed_neighbor_list_table_core: watches the config, request and
// response channels, predicts each response and compares it field by field.
// Depends on pnlt_pkg for field widths, beat layouts and operation/status codes.
module pnlt_checker #(
   parameter int MAX_NEIGHBORS = 32,
   parameter int MAX_POINTS    = 1024,
   parameter int STORE_ENTRIES = 8192
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [pnlt_pkg::PCNT_W-1:0]     csr_wr_data,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [pnlt_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [pnlt_pkg::MODE_W-1:0]     req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [pnlt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [pnlt_pkg::STAT_W-1:0]     rsp_tuser,
   output int                              fail_count,
   output int                              open_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [pnlt_pkg::STAT_W-1:0] status;
      logic [pnlt_pkg::PIDX_W-1:0] nb;
      logic [pnlt_pkg::DIST_W-1:0] distance;
      logic [pnlt_pkg::LEN_W-1:0]  len;
   } rsp_beat_type;

   // shadow copy of the table
   logic [pnlt_pkg::LEN_W-1:0]  cnt_mem  [MAX_POINTS];
   logic [13:0]                 off_mem  [MAX_POINTS];
   logic [pnlt_pkg::PIDX_W-1:0] pend_nb  [MAX_NEIGHBORS];
   logic [pnlt_pkg::DIST_W-1:0] pend_dist[MAX_NEIGHBORS];
   logic [pnlt_pkg::PIDX_W-1:0] st_nb    [STORE_ENTRIES];
   logic [pnlt_pkg::DIST_W-1:0] st_dist  [STORE_ENTRIES];
   logic [pnlt_pkg::LEN_W-1:0]  pend_len;
   logic [pnlt_pkg::PIDX_W-1:0] sel_pt;
   logic [13:0]                 fill_ptr;
   logic [pnlt_pkg::PCNT_W-1:0] pt_limit;

   rsp_beat_type rsp_due_q[$];
   rsp_beat_type due;
   int           fails = 0;

   function automatic bit point_ok(input logic [pnlt_pkg::PIDX_W-1:0] p);
      return ({1'b0, p} < pt_limit) && (int'(p) < MAX_POINTS);
   endfunction

   function automatic rsp_beat_type table_response(
         input logic [pnlt_pkg::MODE_W-1:0] mode,
         input logic [pnlt_pkg::PIDX_W-1:0] pidx,
         input logic [pnlt_pkg::DIST_W-1:0] dist_bits,
         input logic [pnlt_pkg::SLOT_W-1:0] slot);
      rsp_beat_type r;
      int           pos;
      r = '0;
      case (mode)
         pnlt_pkg::MODE_CLEAR: begin
            for (int i = 0; i < MAX_POINTS; i++) begin
               cnt_mem[i] = '0;
               off_mem[i] = '0;
            end
            fill_ptr = '0;
         end
         pnlt_pkg::MODE_PREPARE: begin
            if (!point_ok(pidx)) r.status = pnlt_pkg::STAT_BAD_POINT;
            else begin
               sel_pt   = pidx;
               pend_len = '0;
            end
         end
         pnlt_pkg::MODE_ADD: begin
            if (int'(pend_len) >= MAX_NEIGHBORS) r.status = pnlt_pkg::STAT_LIST_FULL;
            else begin
               pend_nb[int'(pend_len)]   = pidx;
               pend_dist[int'(pend_len)] = dist_bits;
               pend_len                  = pend_len + 1'b1;
            end
            r.len = pend_len;
         end
         pnlt_pkg::MODE_COMMIT: begin
            // empty list: nothing happens; a kept list may be committed again
            if (pend_len != '0) begin
               if (!point_ok(sel_pt)) r.status = pnlt_pkg::STAT_BAD_POINT;
               else if (int'(fill_ptr) + int'(pend_len) > STORE_ENTRIES)
                  r.status = pnlt_pkg::STAT_OVERFLOW;
               else begin
                  cnt_mem[sel_pt] = pend_len;
                  off_mem[sel_pt] = fill_ptr;
                  for (int i = 0; i < int'(pend_len); i++) begin
                     st_nb[int'(fill_ptr) + i]   = pend_nb[i];
                     st_dist[int'(fill_ptr) + i] = pend_dist[i];
                  end
                  fill_ptr = fill_ptr + 14'(pend_len);
               end
            end
         end
         pnlt_pkg::MODE_QUERY: begin
            if (!point_ok(pidx)) r.status = pnlt_pkg::STAT_BAD_POINT;
            else begin
               r.len = cnt_mem[pidx];
               if ({1'b0, slot} >= cnt_mem[pidx]) r.status = pnlt_pkg::STAT_BAD_SLOT;
               else begin
                  pos = int'(off_mem[pidx]) + int'(slot);
                  if (pos < STORE_ENTRIES) begin
                     r.nb       = st_nb[pos];
                     r.distance = st_dist[pos];
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_POINTS; i++) begin
            cnt_mem[i] = '0;
            off_mem[i] = '0;
         end
         for (int i = 0; i < MAX_NEIGHBORS; i++) begin
            pend_nb[i]   = '0;
            pend_dist[i] = '0;
         end
         for (int i = 0; i < STORE_ENTRIES; i++) begin
            st_nb[i]   = '0;
            st_dist[i] = '0;
         end
         pend_len = '0;
         sel_pt   = '0;
         fill_ptr = '0;
         pt_limit = '0;
         rsp_due_q.delete();
      end else begin
         if (csr_wr_en) pt_limit = csr_wr_data;
         // retire the oldest expectation before queuing a new one
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_due_q.size() == 0) begin
               $error("unexpected response beat: status %0d", rsp_tuser);
               fails++;
            end else begin
               due = rsp_due_q.pop_front();
               if (rsp_tuser !== due.status) begin
                  $error("status: expected %0d, actual %0d", due.status, rsp_tuser);
                  fails++;
               end
               if (rsp_tdata[pnlt_pkg::RSP_NB_LO +: pnlt_pkg::PIDX_W] !== due.nb) begin
                  $error("neighbor_out: expected %0d, actual %0d", due.nb,
                         rsp_tdata[pnlt_pkg::RSP_NB_LO +: pnlt_pkg::PIDX_W]);
                  fails++;
               end
               if (rsp_tdata[pnlt_pkg::RSP_DIST_LO +: pnlt_pkg::DIST_W] !== due.distance)
               begin
                  $error("distance_out: expected %h, actual %h", due.distance,
                         rsp_tdata[pnlt_pkg::RSP_DIST_LO +: pnlt_pkg::DIST_W]);
                  fails++;
               end
               if (rsp_tdata[pnlt_pkg::RSP_LEN_LO +: pnlt_pkg::LEN_W] !== due.len) begin
                  $error("list_length: expected %0d, actual %0d", due.len,
                         rsp_tdata[pnlt_pkg::RSP_LEN_LO +: pnlt_pkg::LEN_W]);
                  fails++;
               end
            end
         end
         if (req_tvalid && req_tready)
            rsp_due_q.push_back(table_response(
               req_tuser,
               req_tdata[pnlt_pkg::REQ_PIDX_LO +: pnlt_pkg::PIDX_W],
               req_tdata[pnlt_pkg::REQ_DIST_LO +: pnlt_pkg::DIST_W],
               req_tdata[pnlt_pkg::REQ_SLOT_LO +: pnlt_pkg::SLOT_W]));
      end
      open_count <= rsp_due_q.size();
      fail_count <= fails;
   end

endmodule

FILE: dv/tb_packed_neighbor_list_table_core.sv
// Testbench top for packed_neighbor_list_table_core: clock, reset, request stimulus,
// response back-pressure and the final verdict. Depends on pnlt_pkg and pnlt_checker.
module tb_packed_neighbor_list_table_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_MAX = 32;
   localparam int POINTS   = 1024;
   localparam int ENTRIES  = 8192;
   localparam int RANDOM_BEATS = 1900;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            csr_wr_en   = 1'b0;
   logic [pnlt_pkg::PCNT_W-1:0]     csr_wr_data = '0;
   logic                            req_tvalid  = 1'b0;
   wire                             req_tready;
   logic [pnlt_pkg::REQ_DATA_W-1:0] req_tdata   = '0;
   logic [pnlt_pkg::MODE_W-1:0]     req_tuser   = '0;
   wire                             rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   wire  [pnlt_pkg::RSP_DATA_W-1:0] rsp_tdata;
   wire  [pnlt_pkg::STAT_W-1:0]     rsp_tuser;
   int                              fail_count;
   int                              open_count;

   // stimulus bookkeeping
   int                              items_done = 0;
   bit                              tx_steady  = 1'b0;
   logic [pnlt_pkg::PCNT_W-1:0]     cur_points = '0;
   logic [pnlt_pkg::PIDX_W-1:0]     last_pt    = '0;
   int                              last_len   = 0;

   packed_neighbor_list_table_core #(
      .MAX_NEIGHBORS(LIST_MAX),
      .MAX_POINTS   (POINTS),
      .STORE_ENTRIES(ENTRIES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   pnlt_checker #(
      .MAX_NEIGHBORS(LIST_MAX),
      .MAX_POINTS   (POINTS),
      .STORE_ENTRIES(ENTRIES)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .open_count (open_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Idle length: mostly none, often short, now and then a long one.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Pick a point, mostly inside the configured range.
   function automatic logic [pnlt_pkg::PIDX_W-1:0] pick_point();
      int lim;
      lim = (int'(cur_points) > POINTS) ? POINTS : int'(cur_points);
      if (lim == 0 || $urandom_range(0, 7) == 0) return pnlt_pkg::PIDX_W'($urandom);
      return pnlt_pkg::PIDX_W'($urandom_range(0, lim - 1));
   endfunction

   // Offer one request beat and hold it until the block takes it. Returns at the
   // accepting edge with tvalid still high, so a following beat can go back to back.
   task automatic offer_beat(input logic [pnlt_pkg::MODE_W-1:0] mode,
                             input logic [pnlt_pkg::PIDX_W-1:0] pidx,
                             input logic [pnlt_pkg::DIST_W-1:0] dist_bits,
                             input logic [pnlt_pkg::SLOT_W-1:0] slot);
      int                              gap;
      logic [pnlt_pkg::REQ_DATA_W-1:0] d;
      gap = tx_steady ? 0 : idle_len();
      d = '0;
      d[pnlt_pkg::REQ_PIDX_LO +: pnlt_pkg::PIDX_W] = pidx;
      d[pnlt_pkg::REQ_DIST_LO +: pnlt_pkg::DIST_W] = dist_bits;
      d[pnlt_pkg::REQ_SLOT_LO +: pnlt_pkg::SLOT_W] = slot;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // unused modes get an OK response and change nothing: leave them out of the beat count
      if (mode <= pnlt_pkg::MODE_QUERY) items_done++;
   endtask

   // Drop tvalid and wait until every predicted response has come back.
   task automatic drain_table();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write point_count while the block is idle.
   task automatic set_points(input logic [pnlt_pkg::PCNT_W-1:0] value);
      drain_table();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      cur_points   = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Select a point and append k neighbors with random content.
   task automatic stage_list(input logic [pnlt_pkg::PIDX_W-1:0] pt, input int k);
      offer_beat(pnlt_pkg::MODE_PREPARE, pt, $urandom, pnlt_pkg::SLOT_W'($urandom));
      for (int i = 0; i < k; i++)
         offer_beat(pnlt_pkg::MODE_ADD, pnlt_pkg::PIDX_W'($urandom), $urandom,
                    pnlt_pkg::SLOT_W'($urandom));
      last_pt  = pt;
      last_len = (k > LIST_MAX) ? LIST_MAX : k;
   endtask

   // Response side: ready runs broken by random stalls, plus two long hold-offs
   // that let the block fill up and stall its request side.
   initial begin
      int run;
      int gap;
      int elapsed;
      int holds;
      elapsed = 0;
      holds   = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holds < 2 && elapsed >= 3000 + holds * 12000) begin
            rsp_tready <= 1'b0;
            repeat (500) @(posedge clock);
            elapsed += 500;
            holds++;
         end
         run = $urandom_range(1, 80);
         gap = idle_len();
         rsp_tready <= 1'b1;
         repeat (run) @(posedge clock);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         elapsed += run + gap;
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #4_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int                          pick;
      int                          k;
      int                          phase_end;
      bit                          burst_done;
      logic [pnlt_pkg::PIDX_W-1:0] full_pt;
      logic [pnlt_pkg::MODE_W-1:0] m;
      logic [pnlt_pkg::PCNT_W-1:0] pc;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // point_count is zero out of reset: every point is out of range
      offer_beat(pnlt_pkg::MODE_PREPARE, '0, '0, '0);
      offer_beat(pnlt_pkg::MODE_QUERY, '0, '0, '0);

      // widest setting; build a two-entry list on the top point with extreme data
      set_points('1);
      offer_beat(pnlt_pkg::MODE_PREPARE, '1, '0, '0);
      offer_beat(pnlt_pkg::MODE_ADD, '1, '1, '1);
      offer_beat(pnlt_pkg::MODE_ADD, '0, '0, '0);
      offer_beat(pnlt_pkg::MODE_COMMIT, '0, '0, '0);
      offer_beat(pnlt_pkg::MODE_QUERY, '1, '0, 5'd0);
      offer_beat(pnlt_pkg::MODE_QUERY, '1, '0, 5'd1);
      offer_beat(pnlt_pkg::MODE_QUERY, '1, '0, 5'd2);
      offer_beat(pnlt_pkg::MODE_QUERY, '1, '1, '1);
      // commit keeps the pending list: store it a second time
      offer_beat(pnlt_pkg::MODE_COMMIT, '0, '0, '0);
      offer_beat(pnlt_pkg::MODE_QUERY, '1, '0, 5'd1);

      // unused modes with every field bit set
      for (int u = int'(pnlt_pkg::MODE_QUERY) + 1; u < (1 << pnlt_pkg::MODE_W); u++)
         offer_beat(pnlt_pkg::MODE_W'(u), '1, '1, '1);

      // clear drops counts but keeps the pending list
      offer_beat(pnlt_pkg::MODE_CLEAR, '0, '0, '0);
      offer_beat(pnlt_pkg::MODE_QUERY, '1, '0, '0);

      // commit of an empty list
      offer_beat(pnlt_pkg::MODE_PREPARE, pnlt_pkg::PIDX_W'(5), '0, '0);
      offer_beat(pnlt_pkg::MODE_COMMIT, '0, '0, '0);

      // shrink the range under the selected point, then commit
      offer_beat(pnlt_pkg::MODE_ADD, pnlt_pkg::PIDX_W'(7), $urandom, '0);
      set_points(pnlt_pkg::PCNT_W'(1));
      offer_beat(pnlt_pkg::MODE_COMMIT, '0, '0, '0);
      offer_beat(pnlt_pkg::MODE_PREPARE, '0, '0, '0);
      offer_beat(pnlt_pkg::MODE_PREPARE, pnlt_pkg::PIDX_W'(1), '0, '0);

      // ---- random part ----
      items_done = 0;
      phase_end  = 0;
      burst_done = 1'b0;
      while (items_done < RANDOM_BEATS) begin
         if (items_done >= phase_end) begin
            // new setting, extremes weighted in
            case ($urandom_range(0, 7))
               0: pc = '0;
               1: pc = pnlt_pkg::PCNT_W'(1);
               2: pc = pnlt_pkg::PCNT_W'(POINTS);
               3: pc = pnlt_pkg::PCNT_W'(POINTS + 1);
               4: pc = '1;
               5: pc = pnlt_pkg::PCNT_W'($urandom_range(2, 16));
               default: pc = pnlt_pkg::PCNT_W'($urandom_range(2, POINTS - 1));
            endcase
            set_points(pc);
            phase_end = items_done + $urandom_range(150, 400);
         end

         if (!burst_done && items_done >= 800) begin
            // Fill the store to the brim: a full list (one add refused), committed
            // over and over until it fits exactly, then a further commit of it and a one-entry list overflow.
            set_points(pnlt_pkg::PCNT_W'(POINTS));
            offer_beat(pnlt_pkg::MODE_CLEAR, '0, '0, '0);
            full_pt = pick_point();
            stage_list(full_pt, LIST_MAX + 1);
            repeat (ENTRIES / LIST_MAX) offer_beat(pnlt_pkg::MODE_COMMIT, '0, '0, '0);
            offer_beat(pnlt_pkg::MODE_COMMIT, '0, '0, '0);
            stage_list(pick_point(), 1);
            offer_beat(pnlt_pkg::MODE_COMMIT, '0, '0, '0);
            offer_beat(pnlt_pkg::MODE_QUERY, full_pt, '0, '0);
            offer_beat(pnlt_pkg::MODE_QUERY, full_pt, '0, '1);
            offer_beat(pnlt_pkg::MODE_QUERY, full_pt, '0, pnlt_pkg::SLOT_W'($urandom));
            offer_beat(pnlt_pkg::MODE_CLEAR, '0, '0, '0);
            burst_done = 1'b1;
            phase_end  = items_done;
            continue;
         end

         // a stretch without idling on the request side now and then
         tx_steady = ($urandom_range(0, 5) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            // well-formed: prepare, add, commit, read back
            case ($urandom_range(0, 9))
               0:       k = 0;
               8, 9:    k = $urandom_range(9, LIST_MAX + 4);
               default: k = $urandom_range(1, 8);
            endcase
            stage_list(pick_point(), k);
            offer_beat(pnlt_pkg::MODE_COMMIT, pnlt_pkg::PIDX_W'($urandom), $urandom,
                       pnlt_pkg::SLOT_W'($urandom));
            if ($urandom_range(0, 4) == 0)
               offer_beat(pnlt_pkg::MODE_COMMIT, '0, '0, '0);
            repeat ($urandom_range(1, 4))
               offer_beat(pnlt_pkg::MODE_QUERY, last_pt, $urandom,
                          pnlt_pkg::SLOT_W'($urandom_range(0,
                                            (last_len > 31) ? 31 : last_len)));
         end else if (pick < 75) begin
            // reads spread over the table
            repeat ($urandom_range(1, 6))
               offer_beat(pnlt_pkg::MODE_QUERY, pick_point(), $urandom,
                          ($urandom_range(0, 1) == 0)
                             ? pnlt_pkg::SLOT_W'($urandom_range(0, 3))
                             : pnlt_pkg::SLOT_W'($urandom));
         end else if (pick < 92) begin
            // noise: any mode, any content; keep clears rare since they are slow
            repeat ($urandom_range(1, 4)) begin
               m = pnlt_pkg::MODE_W'($urandom);
               if (m == pnlt_pkg::MODE_CLEAR && $urandom_range(0, 4) != 0)
                  m = pnlt_pkg::MODE_QUERY;
               offer_beat(m, pnlt_pkg::PIDX_W'($urandom), $urandom,
                          pnlt_pkg::SLOT_W'($urandom));
            end
         end else begin
            // broken sequences
            case ($urandom_range(0, 2))
               0: begin
                  repeat ($urandom_range(1, 3))
                     offer_beat(pnlt_pkg::MODE_ADD, pnlt_pkg::PIDX_W'($urandom), $urandom,
                                pnlt_pkg::SLOT_W'($urandom));
                  offer_beat(pnlt_pkg::MODE_COMMIT, '0, '0, '0);
               end
               1: begin
                  offer_beat(pnlt_pkg::MODE_PREPARE, pnlt_pkg::PIDX_W'($urandom), '0, '0);
                  offer_beat(pnlt_pkg::MODE_COMMIT, '0, '0, '0);
               end
               default: begin
                  offer_beat(pnlt_pkg::MODE_COMMIT, '0, '0, '0);
                  offer_beat(pnlt_pkg::MODE_COMMIT, '0, '0, '0);
               end
            endcase
         end
      end

      // drain and let the pipeline settle before the verdict
      tx_steady = 1'b0;
      drain_table();
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
